>>> src/dcrle_pkg.sv
// Shared types and constants for the DCT coefficient run-length encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package dcrle_pkg;

  localparam int COEFF_W = 16;
  localparam int RUN_W   = 6;
  localparam int VALUE_W = 17;
  localparam int KIND_W  = 2;
  localparam logic [RUN_W-1:0] RUN_MAX = 6'd63;

  typedef enum logic [KIND_W-1:0] {
    KIND_DC  = 2'd0,
    KIND_AC  = 2'd1,
    KIND_EOB = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [RUN_W-1:0]           run;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
  } result_t;

  // Up to two results pushed into the result queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

>>> src/dcrle_encode.sv
// Input register, predictor/position state and result formation.
// Depends on dcrle_pkg.
`default_nettype none

module dcrle_encode #(
  parameter int BLOCK_COEFFS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dcrle_pkg::COEFF_W-1:0] in_coeff,
  input  wire logic                          in_start_of_image,
  input  wire logic                          can_push,
  output dcrle_pkg::push_t                   push
);
  import dcrle_pkg::*;

  localparam int PW = $clog2(BLOCK_COEFFS);
  localparam logic [PW-1:0] END_POS = PW'(BLOCK_COEFFS - 1);

  logic                item_vld_r;
  logic [COEFF_W-1:0]  coeff_r;
  logic                sof_r;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [RUN_W-1:0]    zrun_r, zrun_nxt;
  logic [COEFF_W-1:0]  prev_dc_r, prev_dc_nxt;
  logic                first_r, first_nxt;

  logic [PW-1:0]       pos_eff;
  logic [RUN_W-1:0]    zrun_eff;
  logic [COEFF_W-1:0]  prev_eff;
  logic                first_eff;
  logic signed [VALUE_W-1:0] c_ext, prev_ext;
  logic                at_dc, at_end, coeff_nz, has_first;
  result_t             dc_res, ac_res, eob_res, res0, res1;
  logic [1:0]          n_res;
  logic                advance, load;

  assign advance  = item_vld_r && can_push;
  assign in_ready = !item_vld_r || can_push;
  assign load     = in_valid && in_ready;

  always_comb begin
    // start of image wipes the state ahead of this coefficient
    pos_eff   = sof_r ? '0 : pos_r;
    zrun_eff  = sof_r ? '0 : zrun_r;
    prev_eff  = sof_r ? '0 : prev_dc_r;
    first_eff = sof_r ? 1'b1 : first_r;

    c_ext    = $signed({coeff_r[COEFF_W-1], coeff_r});
    prev_ext = $signed({prev_eff[COEFF_W-1], prev_eff});
    at_dc    = (pos_eff == '0);
    at_end   = (pos_eff == END_POS);
    coeff_nz = (coeff_r != '0);
    has_first = at_dc || coeff_nz;

    dc_res.kind  = KIND_DC;
    dc_res.run   = '0;
    dc_res.value = first_eff ? c_ext : c_ext - prev_ext;
    dc_res.last  = !at_end;

    ac_res.kind  = KIND_AC;
    ac_res.run   = zrun_eff;
    ac_res.value = c_ext;
    ac_res.last  = !at_end;

    eob_res.kind  = KIND_EOB;
    eob_res.run   = '0;
    eob_res.value = '0;
    eob_res.last  = 1'b1;

    if (has_first) begin
      res0  = at_dc ? dc_res : ac_res;
      res1  = eob_res;
      n_res = at_end ? 2'd2 : 2'd1;
    end else begin
      res0  = eob_res;
      res1  = eob_res;
      n_res = at_end ? 2'd1 : 2'd0;
    end

    push.cnt  = advance ? n_res : 2'd0;
    push.res0 = res0;
    push.res1 = res1;

    pos_nxt = at_end ? '0 : pos_eff + 1'b1;
    if (at_end || at_dc || coeff_nz) begin
      zrun_nxt = '0;
    end else if (zrun_eff < RUN_MAX) begin
      zrun_nxt = zrun_eff + 1'b1;
    end else begin
      zrun_nxt = zrun_eff;
    end
    prev_dc_nxt = at_dc ? coeff_r : prev_eff;
    first_nxt   = at_dc ? 1'b0 : first_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      pos_r      <= '0;
      zrun_r     <= '0;
      prev_dc_r  <= '0;
      first_r    <= 1'b1;
    end else begin
      if (load) begin
        item_vld_r <= 1'b1;
      end else if (advance) begin
        item_vld_r <= 1'b0;
      end
      if (advance) begin
        pos_r     <= pos_nxt;
        zrun_r    <= zrun_nxt;
        prev_dc_r <= prev_dc_nxt;
        first_r   <= first_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      coeff_r <= in_coeff;
      sof_r   <= in_start_of_image;
    end
  end

endmodule

`default_nettype wire

>>> src/dcrle_res_fifo.sv
// Four-entry result queue: up to two results in a cycle, one out on ready.
// Depends on dcrle_pkg.
`default_nettype none

module dcrle_res_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  dcrle_pkg::push_t                   push,
  output logic                               can_push,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dcrle_pkg::KIND_W-1:0]       out_kind,
  output logic [dcrle_pkg::RUN_W-1:0]       out_run,
  output logic signed [dcrle_pkg::VALUE_W-1:0] out_value,
  output logic                               out_last
);
  import dcrle_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  result_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r, count_nxt;
  logic            pop;
  result_t         head;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  // room for a worst-case pair regardless of the output side
  assign can_push  = (count_r <= (AW+1)'(DEPTH - 2));
  assign count_nxt = count_r + (AW+1)'(push.cnt) - (AW+1)'(pop);

  assign head      = mem[rd_ptr_r];
  assign out_kind  = head.kind;
  assign out_run   = head.run;
  assign out_value = head.value;
  assign out_last  = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push.cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + 1'b1] <= push.res1;
    end
  end

endmodule

`default_nettype wire

>>> src/dct_coeff_run_length_encoder.sv
// DCT coefficient run-length encoder, top level.
// Depends on dcrle_pkg, dcrle_encode and dcrle_res_fifo.
//
// Takes one zigzag-ordered quantized coefficient per transaction, one per
// cycle, and emits JPEG-style results: a DC difference (raw DC on the first
// block after reset or start of image), a run/value pair per nonzero AC
// coefficient, and an end-of-block marker after coefficient BLOCK_COEFFS-1.
// Zero AC coefficients produce no result, but a zero final one still yields
// the end of block; the final coefficient can produce two (AC pair then end of
// block), with last set on the end of block, not the pair; other results set it.
// An item is registered on entry, encoded and written into a four-entry
// result queue; out_valid rises once the queue holds its result, and the write
// waits while can_push is low. Input sustains one coefficient per cycle; the
// queue drains one result per cycle, so the rate is set by the output side:
// ready drops only when the queue could not absorb a two-result item.
`default_nettype none

module dct_coeff_run_length_encoder #(
  parameter int BLOCK_COEFFS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [dcrle_pkg::COEFF_W-1:0]     in_coeff,
  input  wire logic                              in_start_of_image,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [dcrle_pkg::KIND_W-1:0]           out_kind,
  output logic [dcrle_pkg::RUN_W-1:0]            out_run,
  output logic signed [dcrle_pkg::VALUE_W-1:0]   out_value,
  output logic                                   out_last
);
  import dcrle_pkg::*;

  push_t push;
  logic  can_push;

  dcrle_encode #(
    .BLOCK_COEFFS(BLOCK_COEFFS)
  ) u_encode (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_coeff          (in_coeff),
    .in_start_of_image (in_start_of_image),
    .can_push          (can_push),
    .push              (push)
  );

  dcrle_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_run   (out_run),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire
